[design/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Needs a signal named clock and a signal named reset in the using scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define RPA_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent that follows in the cycle after the antecedent.
`define RPA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/rpa_pkg.sv]
// Package of the reference-counted page allocator: codes, transaction types, defaults.
// No dependencies.
package rpa_pkg;

   localparam int DEF_NUM_PAGES  = 32768;
   localparam int DEF_COUNT_BITS = 8;
   localparam int PAGE_BITS      = 15;
   localparam int OUT_COUNT_BITS = 8;

   typedef enum logic [1:0] {
      ACT_ALLOC  = 2'd0,
      ACT_FREE   = 2'd1,
      ACT_INCREF = 2'd2,
      ACT_ADD    = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      ST_OK     = 3'd0,
      ST_EMPTY  = 3'd1,
      ST_RANGE  = 3'd2,
      ST_DOUBLE = 3'd3,
      ST_SAT    = 3'd4
   } status_type;

   typedef struct packed {
      action_type             action;
      logic [PAGE_BITS-1:0]   page;
   } req_type;

   typedef struct packed {
      status_type                status;
      logic [PAGE_BITS-1:0]      granted_page;
      logic                      returned_to_pool;
      logic [OUT_COUNT_BITS-1:0] ref_count;
   } rsp_type;

endpackage

[design/rpa_stack_mem.sv]
// Free-page stack storage: one write port, one registered read port.
// Depends on rpa_pkg for the page width.
module rpa_stack_mem #(
   parameter int NUM_PAGES = rpa_pkg::DEF_NUM_PAGES
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(NUM_PAGES)-1:0]  wr_addr,
   input  logic [rpa_pkg::PAGE_BITS-1:0] wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(NUM_PAGES)-1:0]  rd_addr,
   output logic [rpa_pkg::PAGE_BITS-1:0] rd_data
);

   logic [rpa_pkg::PAGE_BITS-1:0] mem [NUM_PAGES];
   logic [rpa_pkg::PAGE_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/rpa_count_mem.sv]
// Per-page reference count memory with a zeroing sweep after reset.
// Depends on rpa_pkg for parameter defaults.
module rpa_count_mem #(
   parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
   parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   output logic                          clearing,
   input  logic                          rd_en,
   input  logic [$clog2(NUM_PAGES)-1:0]  rd_addr,
   output logic [COUNT_BITS-1:0]         rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(NUM_PAGES)-1:0]  wr_addr,
   input  logic [COUNT_BITS-1:0]         wr_data
);

   localparam int AW = $clog2(NUM_PAGES);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_PAGES - 1);

   logic [COUNT_BITS-1:0] mem [NUM_PAGES];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [AW-1:0]         clr_addr_ff;
   logic                  clearing_ff;
   logic                  mem_we;
   logic [AW-1:0]         mem_addr;
   logic [COUNT_BITS-1:0] mem_wdata;

   always_comb begin
      mem_we    = clearing_ff || wr_en;
      mem_addr  = clearing_ff ? clr_addr_ff : wr_addr;
      mem_wdata = clearing_ff ? '0 : wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign clearing = clearing_ff;
   assign rd_data  = rd_data_ff;

endmodule

[design/refcounted_page_allocator.sv]
// Reference-counted page allocator: LIFO free stack plus per-page counts.
// A request taken in S_IDLE is executed in S_EXEC, whose registered result drives the strobe.
// busy holds off a new request until the count memory read-modify-write of the last one is done.
// Reset: counts are zeroed by a sweep over all NUM_PAGES entries, busy high meanwhile.
// The result strobe cannot be stalled by the receiver.
// Depends on rpa_pkg, rpa_count_mem, rpa_stack_mem and assert_macros.svh.
`include "assert_macros.svh"

module refcounted_page_allocator #(
   parameter int NUM_PAGES  = rpa_pkg::DEF_NUM_PAGES,
   parameter int COUNT_BITS = rpa_pkg::DEF_COUNT_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  rpa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   output rpa_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rpa_pkg::PAGE_BITS-1:0] csr_data
);

   localparam int AW  = $clog2(NUM_PAGES);
   localparam int CW  = $clog2(NUM_PAGES + 1);
   localparam int PW  = rpa_pkg::PAGE_BITS;
   localparam int OCB = rpa_pkg::OUT_COUNT_BITS;
   localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
   localparam logic [CW-1:0]         STACK_FULL = CW'(NUM_PAGES);

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type             state_ff;
   rpa_pkg::req_type      req_ff;
   rpa_pkg::rsp_type      rsp_ff;
   rpa_pkg::rsp_type      rsp_in;
   logic                  rsp_valid_ff;
   logic [CW-1:0]         free_count_ff;
   logic [CW-1:0]         free_count_in;
   logic [PW-1:0]         first_ff;

   logic                  clearing;
   logic                  accept;
   logic                  in_range;
   logic                  push;
   logic [COUNT_BITS-1:0] cnt_rd;
   logic [COUNT_BITS-1:0] cnt_out;
   logic [COUNT_BITS-1:0] cnt_dec;
   logic                  cnt_we;
   logic [AW-1:0]         cnt_waddr;
   logic [COUNT_BITS-1:0] cnt_wdata;
   logic [PW-1:0]         stk_rd;

   assign busy      = clearing || (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   rpa_count_mem #(
      .NUM_PAGES  (NUM_PAGES),
      .COUNT_BITS (COUNT_BITS)
   ) u_count_mem (
      .clock    (clock),
      .reset    (reset),
      .clearing (clearing),
      .rd_en    (accept),
      .rd_addr  (AW'(req_data.page)),
      .rd_data  (cnt_rd),
      .wr_en    (cnt_we),
      .wr_addr  (cnt_waddr),
      .wr_data  (cnt_wdata)
   );

   rpa_stack_mem #(
      .NUM_PAGES (NUM_PAGES)
   ) u_stack_mem (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (AW'(free_count_ff)),
      .wr_data (req_ff.page),
      .rd_en   (accept),
      .rd_addr (AW'(free_count_ff - CW'(1))),
      .rd_data (stk_rd)
   );

   // read data of both memories is valid in S_EXEC
   always_comb begin
      in_range      = (req_ff.page >= first_ff) && (32'(req_ff.page) < 32'(NUM_PAGES));
      cnt_dec       = cnt_rd - COUNT_BITS'(1);
      rsp_in        = '0;
      rsp_in.status = rpa_pkg::ST_OK;
      cnt_out       = '0;
      cnt_we        = 1'b0;
      cnt_waddr     = AW'(req_ff.page);
      cnt_wdata     = '0;
      push          = 1'b0;
      free_count_in = free_count_ff;
      if (state_ff == S_EXEC) begin
         unique case (req_ff.action)
            rpa_pkg::ACT_ALLOC: begin
               if (free_count_ff == '0) begin
                  rsp_in.status = rpa_pkg::ST_EMPTY;
               end else begin
                  free_count_in       = free_count_ff - CW'(1);
                  cnt_we              = 1'b1;
                  cnt_waddr           = AW'(stk_rd);
                  cnt_wdata           = COUNT_BITS'(1);
                  cnt_out             = COUNT_BITS'(1);
                  rsp_in.granted_page = stk_rd;
               end
            end
            rpa_pkg::ACT_FREE: begin
               if (!in_range) begin
                  rsp_in.status = rpa_pkg::ST_RANGE;
               end else if (cnt_rd == '0) begin
                  rsp_in.status = rpa_pkg::ST_DOUBLE;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_dec;
                  cnt_out   = cnt_dec;
                  if (cnt_dec == '0) begin
                     if (free_count_ff == STACK_FULL) begin
                        rsp_in.status = rpa_pkg::ST_DOUBLE;
                     end else begin
                        push = 1'b1;
                     end
                  end
               end
            end
            rpa_pkg::ACT_INCREF: begin
               if (!in_range) begin
                  rsp_in.status = rpa_pkg::ST_RANGE;
               end else if (cnt_rd == CNT_MAX) begin
                  rsp_in.status = rpa_pkg::ST_SAT;
                  cnt_out       = CNT_MAX;
               end else begin
                  cnt_we    = 1'b1;
                  cnt_wdata = cnt_rd + COUNT_BITS'(1);
                  cnt_out   = cnt_rd + COUNT_BITS'(1);
               end
            end
            rpa_pkg::ACT_ADD: begin
               if (!in_range) begin
                  rsp_in.status = rpa_pkg::ST_RANGE;
               end else begin
                  cnt_we = 1'b1;
                  if (free_count_ff == STACK_FULL) begin
                     rsp_in.status = rpa_pkg::ST_DOUBLE;
                  end else begin
                     push = 1'b1;
                  end
               end
            end
         endcase
         if (push) begin
            free_count_in = free_count_ff + CW'(1);
         end
      end
      rsp_in.returned_to_pool = push;
      rsp_in.ref_count        = OCB'(cnt_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         free_count_ff <= '0;
         first_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               rsp_valid_ff <= 1'b0;
               if (accept) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               state_ff      <= S_IDLE;
               free_count_ff <= free_count_in;
               rsp_valid_ff  <= 1'b1;
            end
         endcase
         if (csr_valid && csr_ready) begin
            first_ff <= csr_data;
         end
      end
      if (accept) begin
         req_ff <= req_data;
      end
      if (state_ff == S_EXEC) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RPA_ASSERT_NEXT(a_one_result, accept, ##1 rsp_valid, "accepted request gave no result")
   `RPA_ASSERT_ALWAYS(a_count_bound, free_count_ff <= STACK_FULL, "free count beyond depth")
   `RPA_ASSERT_ALWAYS(a_push_clean,
      !(rsp_valid && rsp_data.returned_to_pool) || (rsp_data.status == rpa_pkg::ST_OK
      && rsp_data.ref_count == '0 && rsp_data.granted_page == '0),
      "push with bad result fields")
   `RPA_ASSERT_NEXT(a_no_write_idle, state_ff == S_IDLE && !accept, !rsp_valid,
      "result without request")

endmodule

[bench/page_alloc_check.sv]
// Checker for the reference-counted page allocator: predicts each result from the
// accepted requests and register writes, then compares the strobed results in order.
// Depends on rpa_pkg.
module page_alloc_check (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          busy,
   input  rpa_pkg::req_type              req_data,
   input  logic                          rsp_valid,
   input  rpa_pkg::rsp_type              rsp_data,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  logic [rpa_pkg::PAGE_BITS-1:0] csr_data,
   output int                            failures,
   output int                            pending,
   output int                            checked,
   output logic [4:0]                    status_hits
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGES = rpa_pkg::DEF_NUM_PAGES;
   localparam int PB    = rpa_pkg::PAGE_BITS;
   localparam logic [7:0] COUNT_TOP = 8'hFF;

   logic [PB-1:0]        lowest_page;
   logic [7:0]           use_count [PAGES];
   logic [PB-1:0]        free_pages [PAGES];
   int unsigned          stack_depth;
   rpa_pkg::rsp_type     expected_q [$];

   function automatic logic page_usable(input logic [PB-1:0] pg);
      return (pg >= lowest_page) && (32'(pg) < PAGES);
   endfunction

   function automatic logic push_free(input logic [PB-1:0] pg);
      if (stack_depth >= PAGES) return 1'b0;
      free_pages[stack_depth] = pg;
      stack_depth++;
      return 1'b1;
   endfunction

   function automatic rpa_pkg::rsp_type predict_page_op(input rpa_pkg::req_type r);
      rpa_pkg::rsp_type o;
      o = '0;
      o.status = rpa_pkg::ST_OK;
      if (r.action == rpa_pkg::ACT_ALLOC) begin
         if (stack_depth == 0) begin
            o.status = rpa_pkg::ST_EMPTY;
         end else begin
            stack_depth--;
            o.granted_page = free_pages[stack_depth];
            use_count[o.granted_page] = 8'd1;
            o.ref_count = 8'd1;
         end
      end else if (!page_usable(r.page)) begin
         o.status = rpa_pkg::ST_RANGE;
      end else if (r.action == rpa_pkg::ACT_FREE) begin
         if (use_count[r.page] == 0) begin
            o.status = rpa_pkg::ST_DOUBLE;
         end else begin
            use_count[r.page] = use_count[r.page] - 8'd1;
            o.ref_count = use_count[r.page];
            if (use_count[r.page] == 0) begin
               if (push_free(r.page)) o.returned_to_pool = 1'b1;
               else o.status = rpa_pkg::ST_DOUBLE;
            end
         end
      end else if (r.action == rpa_pkg::ACT_INCREF) begin
         if (use_count[r.page] >= COUNT_TOP) begin
            use_count[r.page] = COUNT_TOP;
            o.status = rpa_pkg::ST_SAT;
         end else begin
            use_count[r.page] = use_count[r.page] + 8'd1;
         end
         o.ref_count = use_count[r.page];
      end else begin
         // set to one then freed at once: ends at zero
         use_count[r.page] = 8'd0;
         if (push_free(r.page)) o.returned_to_pool = 1'b1;
         else o.status = rpa_pkg::ST_DOUBLE;
      end
      return o;
   endfunction

   task automatic compare_result(input rpa_pkg::rsp_type got);
      rpa_pkg::rsp_type want;
      logic             bad;
      bad = 1'b0;
      if (expected_q.size() == 0) begin
         $error("result with no transaction outstanding: %h", got);
         failures++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         bad = 1'b1;
      end
      if (got.granted_page !== want.granted_page) begin
         $error("granted_page: expected %0d, got %0d", want.granted_page, got.granted_page);
         bad = 1'b1;
      end
      if (got.returned_to_pool !== want.returned_to_pool) begin
         $error("returned_to_pool: expected %0d, got %0d",
                want.returned_to_pool, got.returned_to_pool);
         bad = 1'b1;
      end
      if (got.ref_count !== want.ref_count) begin
         $error("ref_count: expected %0d, got %0d", want.ref_count, got.ref_count);
         bad = 1'b1;
      end
      if (bad) failures++;
      if (32'(want.status) < 5) status_hits[want.status] = 1'b1;
   endtask

   initial begin
      failures = 0;
      pending = 0;
      checked = 0;
      status_hits = '0;
   end

   always @(posedge clock) begin
      if (reset) begin
         lowest_page = '0;
         stack_depth = 0;
         for (int i = 0; i < PAGES; i++) use_count[i] = 8'd0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) lowest_page = csr_data;
         if (rsp_valid) compare_result(rsp_data);
         if (start && !busy) expected_q.push_back(predict_page_op(req_data));
      end
      pending = expected_q.size();
   end

endmodule

[bench/tb.sv]
// Testbench top for the reference-counted page allocator: clock, reset, requests,
// register writes and the verdict. Checking is done by page_alloc_check.
// Depends on rpa_pkg, refcounted_page_allocator and page_alloc_check.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 1500000;
   localparam int PB          = rpa_pkg::PAGE_BITS;
   localparam int TOP_PAGE    = rpa_pkg::DEF_NUM_PAGES - 1;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 start = 1'b0;
   logic                 busy;
   rpa_pkg::req_type     req_data = '0;
   logic                 rsp_valid;
   rpa_pkg::rsp_type     rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [PB-1:0]        csr_data = '0;

   int         failures;
   int         pending;
   int         checked;
   logic [4:0] status_hits;

   int  items_sent = 0;
   bit  steady = 1'b0;
   int  base_page = 0;

   refcounted_page_allocator dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   page_alloc_check u_alloc_check (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .failures    (failures),
      .pending     (pending),
      .checked     (checked),
      .status_hits (status_hits)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Verification failed");
      $finish;
   end

   task automatic issue(input rpa_pkg::action_type act, input int pg);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 16) gap = $urandom_range(1, 5);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= rpa_pkg::req_type'{act, PB'(pg)};
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // stop sending and wait for every outstanding transaction
   task automatic settle();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_lowest(input int v);
      settle();
      repeat ($urandom_range(0, 3)) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= PB'(v);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      base_page = v;
   endtask

   function automatic int pick_page();
      int r;
      int k;
      r = $urandom_range(99);
      if (r < 70) begin
         k = $urandom_range(0, 31);
         return (base_page + k > TOP_PAGE) ? TOP_PAGE - k : base_page + k;
      end
      if (r < 85) return $urandom_range(0, TOP_PAGE);
      case ($urandom_range(2))
         0:       return (base_page > 0) ? base_page - 1 : 0;
         1:       return base_page;
         default: return TOP_PAGE;
      endcase
   endfunction

   function automatic rpa_pkg::action_type pick_action();
      int r;
      r = $urandom_range(99);
      if (r < 25) return rpa_pkg::ACT_ALLOC;
      if (r < 55) return rpa_pkg::ACT_FREE;
      if (r < 80) return rpa_pkg::ACT_INCREF;
      return rpa_pkg::ACT_ADD;
   endfunction

   initial begin
      int hot;
      int phase_items;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: range edges, empty pool, duplicate push, double free
      set_lowest(8);
      issue(rpa_pkg::ACT_ALLOC, 0);
      issue(rpa_pkg::ACT_FREE, 0);
      issue(rpa_pkg::ACT_INCREF, 7);
      issue(rpa_pkg::ACT_ADD, 7);
      issue(rpa_pkg::ACT_ADD, 8);
      issue(rpa_pkg::ACT_ADD, TOP_PAGE);
      issue(rpa_pkg::ACT_INCREF, TOP_PAGE);
      issue(rpa_pkg::ACT_FREE, TOP_PAGE);
      issue(rpa_pkg::ACT_FREE, TOP_PAGE);
      issue(rpa_pkg::ACT_ALLOC, 0);
      issue(rpa_pkg::ACT_ALLOC, TOP_PAGE);
      issue(rpa_pkg::ACT_INCREF, TOP_PAGE);
      issue(rpa_pkg::ACT_FREE, TOP_PAGE);
      issue(rpa_pkg::ACT_ALLOC, 0);
      issue(rpa_pkg::ACT_ALLOC, 0);
      issue(rpa_pkg::ACT_FREE, 8);
      issue(rpa_pkg::ACT_ADD, 15'h5555);
      issue(rpa_pkg::ACT_ADD, 15'h2AAA);
      issue(rpa_pkg::ACT_INCREF, 15'h5555);
      set_lowest(TOP_PAGE);
      issue(rpa_pkg::ACT_ADD, TOP_PAGE - 1);
      issue(rpa_pkg::ACT_FREE, TOP_PAGE - 1);
      issue(rpa_pkg::ACT_ADD, TOP_PAGE);
      set_lowest(0);
      issue(rpa_pkg::ACT_ADD, 0);
      issue(rpa_pkg::ACT_ALLOC, 0);

      // one page driven into saturation and back down past zero
      set_lowest($urandom_range(1, 100));
      hot = pick_page();
      issue(rpa_pkg::ACT_ADD, hot);
      repeat (258) issue(rpa_pkg::ACT_INCREF, hot);
      repeat (257) issue(rpa_pkg::ACT_FREE, hot);

      for (int ph = 0; items_sent < 1950; ph++) begin
         case (ph % 4)
            0:       set_lowest(0);
            1:       set_lowest(TOP_PAGE);
            2:       set_lowest($urandom_range(1, TOP_PAGE - 1));
            default: set_lowest($urandom_range(1, 64));
         endcase
         steady = (ph == 2);
         phase_items = (ph % 4 == 1) ? 80 : 320;
         repeat (phase_items) begin
            issue(pick_action(), pick_page());
            if ($urandom_range(149) == 0) settle();
         end
      end
      steady = 1'b0;

      settle();
      $display("%0d requests sent, %0d results checked across register settings 0 to %0d",
               items_sent, checked, TOP_PAGE);
      $display("status codes seen (saturated, double, range, empty, ok): %b", status_hits);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
